// ----- design/rgb565_palette_box_downscale_core_assert.svh -----
// Assertion macros for the palette box downscaler.
`ifndef RGB565_PALETTE_BOX_DOWNSCALE_CORE_ASSERT_SVH
`define RGB565_PALETTE_BOX_DOWNSCALE_CORE_ASSERT_SVH

// Checked outside reset.
`define RPBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked during reset as well.
`define RPBD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- design/rpbd_pkg.sv -----
`default_nettype none

package rpbd_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam logic [31:0] SPREAD_MASK      = 32'h07e0_f81f;
    localparam logic [7:0]  TEXT_NIBBLE_MASK = 8'hf0;

    typedef enum logic [2:0] {
        MODE_BLANK  = 3'd0,
        MODE_SINGLE = 3'd1,
        MODE_DUAL   = 3'd2,
        MODE_INTLV  = 3'd3,
        MODE_TEXT   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE       = 2'd0,
        REG_GRAPH_BASE = 2'd1,
        REG_TEXT_BASE  = 2'd2,
        REG_FILL_INDEX = 2'd3
    } t_reg_idx;

    typedef enum logic {
        FUNC_PAL_WRITE = 1'b0,
        FUNC_PIXEL     = 1'b1
    } t_func;

    // Spread RGB565 so green sits in bits 26..21, red and blue in 15..0.
    function automatic logic [31:0] spread(input logic [15:0] c);
        return {c, c} & SPREAD_MASK;
    endfunction

    function automatic logic [15:0] fold1(input logic [31:0] s);
        logic [31:0] t;
        t = s + (s >> 16);
        return t[15:0];
    endfunction

    function automatic logic [15:0] fold2(input logic [31:0] s);
        logic [31:0] w;
        logic [31:0] t;
        w = s & (SPREAD_MASK << 1);
        t = (w >> 1) + (w >> 17);
        return t[15:0];
    endfunction

    function automatic logic [15:0] fold4(input logic [31:0] s);
        logic [31:0] w;
        logic [31:0] t;
        w = s & (SPREAD_MASK << 2);
        t = (w >> 2) + (w >> 18);
        return t[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/rgb565_palette_box_downscale_core.sv -----
// A pixel beat is registered through stages A, B, C, D and E in turn; o_valid is the stage E valid.
// Throughput: one beat per cycle unless held by i_stall or the clearing pass; five register
// stages, palette read in stage three from two copies of the palette with two read ports each.
// Reset: config registers clear to zero, then a clearing pass zeroes the palette,
// one entry a cycle until every entry is zero, with the input stalled meanwhile.
`default_nettype none

`include "rgb565_palette_box_downscale_core_assert.svh"

module rgb565_palette_box_downscale_core #(
    parameter int PALETTE_ENTRIES = rpbd_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_pal_index,
    input  wire logic [15:0] i_pal_color,
    input  wire logic [7:0]  i_a_top_left,
    input  wire logic [7:0]  i_a_top_right,
    input  wire logic [7:0]  i_a_bot_left,
    input  wire logic [7:0]  i_a_bot_right,
    input  wire logic [7:0]  i_b_top_left,
    input  wire logic [7:0]  i_b_top_right,
    input  wire logic [7:0]  i_b_bot_left,
    input  wire logic [7:0]  i_b_bot_right,

    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_pixel,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW = AW + 4;
    localparam logic [CW-1:0] ENTRIES_C = CW'(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX  = AW'(PALETTE_ENTRIES - 1);

    // Reduce a wrapped 8-bit index modulo the palette depth (exact for a depth of 16 or more): four restoring steps.
    function automatic logic [AW-1:0] wrap_idx(input logic [7:0] v);
        logic [CW-1:0] r;
        r = CW'(v);
        for (int k = 3; k >= 0; k--) begin
            if (r >= (ENTRIES_C << k)) begin
                r = r - (ENTRIES_C << k);
            end
        end
        return r[AW-1:0];
    endfunction

    // Configuration registers
    logic [2:0] r_mode;
    logic [7:0] r_graph_base;
    logic [7:0] r_text_base;
    logic [7:0] r_fill_index;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 3'd0;
            r_graph_base <= 8'd0;
            r_text_base  <= 8'd0;
            r_fill_index <= 8'd0;
        end else if (cfg_wr) begin
            unique case (rpbd_pkg::t_reg_idx'(paddr[3:2]))
                rpbd_pkg::REG_MODE:       r_mode       <= pwdata[2:0];
                rpbd_pkg::REG_GRAPH_BASE: r_graph_base <= pwdata[7:0];
                rpbd_pkg::REG_TEXT_BASE:  r_text_base  <= pwdata[7:0];
                rpbd_pkg::REG_FILL_INDEX: r_fill_index <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rpbd_pkg::t_reg_idx'(paddr[3:2]))
            rpbd_pkg::REG_MODE:       prdata = {29'd0, r_mode};
            rpbd_pkg::REG_GRAPH_BASE: prdata = {24'd0, r_graph_base};
            rpbd_pkg::REG_TEXT_BASE:  prdata = {24'd0, r_text_base};
            rpbd_pkg::REG_FILL_INDEX: prdata = {24'd0, r_fill_index};
            default:                  prdata = 32'd0;
        endcase
    end

    // Clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Stage valids and enables
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    logic en_a, en_b, en_c, en_d, en_e;
    logic in_acc;

    assign en_e   = !r_e_vld || !i_stall;
    assign en_d   = !r_d_vld || en_e;
    assign en_c   = !r_c_vld || en_d;
    assign en_b   = !r_b_vld || en_c;
    assign en_a   = !r_a_vld || en_b;
    assign o_stall = !en_a || r_clr_busy;
    assign in_acc  = i_valid && !o_stall;

    // Stage A: register the input beat
    logic        r_a_func;
    logic [7:0]  r_a_pal_index;
    logic [15:0] r_a_pal_color;
    logic [7:0]  r_a_atl, r_a_atr, r_a_abl, r_a_abr;
    logic [7:0]  r_a_btl, r_a_btr, r_a_bbl, r_a_bbr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en_a) begin
            r_a_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && in_acc) begin
            r_a_func      <= i_func;
            r_a_pal_index <= i_pal_index;
            r_a_pal_color <= i_pal_color;
            r_a_atl       <= i_a_top_left;
            r_a_atr       <= i_a_top_right;
            r_a_abl       <= i_a_bot_left;
            r_a_abr       <= i_a_bot_right;
            r_a_btl       <= i_b_top_left;
            r_a_btr       <= i_b_top_right;
            r_a_bbl       <= i_b_bot_left;
            r_a_bbr       <= i_b_bot_right;
        end
    end

    // Stage B: palette addresses
    logic [7:0] n_b_raw0, n_b_raw1, n_b_raw2, n_b_raw3;

    always_comb begin
        case (rpbd_pkg::t_mode'(r_mode))
            rpbd_pkg::MODE_SINGLE, rpbd_pkg::MODE_INTLV: begin
                n_b_raw0 = r_a_atl + r_graph_base;
                n_b_raw1 = r_a_atr + r_graph_base;
                n_b_raw2 = r_a_abl + r_graph_base;
                n_b_raw3 = r_a_abr + r_graph_base;
            end
            rpbd_pkg::MODE_DUAL: begin
                n_b_raw0 = r_a_atl + r_a_btl + r_graph_base;
                n_b_raw1 = r_a_atr + r_a_btr + r_graph_base;
                n_b_raw2 = r_a_abl + r_a_bbl + r_graph_base;
                n_b_raw3 = r_a_abr + r_a_bbr + r_graph_base;
            end
            rpbd_pkg::MODE_TEXT: begin
                n_b_raw0 = r_a_atl + r_a_btl + r_graph_base;
                n_b_raw1 = r_a_atr + r_a_btr + r_graph_base;
                // Use the text entry where the high nibble is set, else reuse the top-row A.
                n_b_raw2 = ((r_a_bbl & rpbd_pkg::TEXT_NIBBLE_MASK) != 8'd0)
                         ? ({4'd0, r_a_bbl[7:4]} + r_text_base)
                         : (r_a_atl + r_graph_base);
                n_b_raw3 = ((r_a_bbr & rpbd_pkg::TEXT_NIBBLE_MASK) != 8'd0)
                         ? ({4'd0, r_a_bbr[7:4]} + r_text_base)
                         : (r_a_atr + r_graph_base);
            end
            default: begin
                n_b_raw0 = r_fill_index;
                n_b_raw1 = r_fill_index;
                n_b_raw2 = r_fill_index;
                n_b_raw3 = r_fill_index;
            end
        endcase
    end

    logic          r_b_func;
    logic [2:0]    r_b_mode;
    logic [AW-1:0] r_b_idx0, r_b_idx1, r_b_idx2, r_b_idx3;
    logic          r_b_wr_ok;
    logic [AW-1:0] r_b_wr_addr;
    logic [15:0]   r_b_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_func    <= r_a_func;
            r_b_mode    <= r_mode;
            r_b_idx0    <= wrap_idx(n_b_raw0);
            r_b_idx1    <= wrap_idx(n_b_raw1);
            r_b_idx2    <= wrap_idx(n_b_raw2);
            r_b_idx3    <= wrap_idx(n_b_raw3);
            // Drop writes beyond the palette depth.
            r_b_wr_ok   <= CW'(r_a_pal_index) < ENTRIES_C;
            r_b_wr_addr <= AW'(r_a_pal_index);
            r_b_wr_data <= r_a_pal_color;
        end
    end

    // Stage C: palette read; two identical copies give four read ports
    logic [15:0]   r_pal_lo [PALETTE_ENTRIES];
    logic [15:0]   r_pal_hi [PALETTE_ENTRIES];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = 16'd0;
        end else begin
            mem_we    = en_c && r_b_vld && (r_b_func == rpbd_pkg::FUNC_PAL_WRITE) && r_b_wr_ok;
            mem_waddr = r_b_wr_addr;
            mem_wdata = r_b_wr_data;
        end
    end

    logic [15:0] r_c_d0, r_c_d1, r_c_d2, r_c_d3;
    logic [2:0]  r_c_mode;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pal_lo[mem_waddr] <= mem_wdata;
            r_pal_hi[mem_waddr] <= mem_wdata;
        end
        if (en_c) begin
            r_c_d0   <= r_pal_lo[r_b_idx0];
            r_c_d1   <= r_pal_lo[r_b_idx1];
            r_c_d2   <= r_pal_hi[r_b_idx2];
            r_c_d3   <= r_pal_hi[r_b_idx3];
            r_c_mode <= r_b_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en_c) begin
            // Palette writes end here and give no result.
            r_c_vld <= r_b_vld && (r_b_func == rpbd_pkg::FUNC_PIXEL);
        end
    end

    // Stage D: spread and sum
    logic [31:0] n_d_sum;

    always_comb begin
        case (rpbd_pkg::t_mode'(r_c_mode))
            rpbd_pkg::MODE_SINGLE, rpbd_pkg::MODE_DUAL, rpbd_pkg::MODE_TEXT: begin
                n_d_sum = rpbd_pkg::spread(r_c_d0) + rpbd_pkg::spread(r_c_d1)
                        + rpbd_pkg::spread(r_c_d2) + rpbd_pkg::spread(r_c_d3);
            end
            rpbd_pkg::MODE_INTLV: begin
                n_d_sum = rpbd_pkg::spread(r_c_d0) + rpbd_pkg::spread(r_c_d1);
            end
            default: begin
                n_d_sum = rpbd_pkg::spread(r_c_d0);
            end
        endcase
    end

    logic [31:0] r_d_sum;
    logic [2:0]  r_d_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en_d) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_sum  <= n_d_sum;
            r_d_mode <= r_c_mode;
        end
    end

    // Stage E: fold back to RGB565 into the output register
    logic [15:0] n_e_pixel;
    logic [15:0] r_e_pixel;

    always_comb begin
        case (rpbd_pkg::t_mode'(r_d_mode))
            rpbd_pkg::MODE_SINGLE, rpbd_pkg::MODE_DUAL, rpbd_pkg::MODE_TEXT:
                n_e_pixel = rpbd_pkg::fold4(r_d_sum);
            rpbd_pkg::MODE_INTLV:
                n_e_pixel = rpbd_pkg::fold2(r_d_sum);
            default:
                n_e_pixel = rpbd_pkg::fold1(r_d_sum);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en_e) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_pixel <= n_e_pixel;
        end
    end

    assign o_valid = r_e_vld;
    assign o_pixel = r_e_pixel;

    // Assertions
    `RPBD_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> r_clr_busy, "clear pass not started by reset")
    `RPBD_ASSERT(a_no_accept_in_clear, r_clr_busy |-> o_stall, "input accepted during clear pass")
    `RPBD_ASSERT(a_pipe_empty_in_clear, r_clr_busy |-> !r_a_vld && !r_b_vld, "beat in pipe during clear")
    `RPBD_ASSERT(a_pal_write_no_result, r_b_vld && !r_b_func && en_c |=> !r_c_vld, "palette write made a result")
    `RPBD_ASSERT(a_stage_b_hold, r_b_vld && !en_b |=> r_b_vld && $stable(r_b_idx0), "stage B lost a stalled beat")

endmodule

`default_nettype wire

// ----- tb/rpbd_tb_pkg.sv -----
package rpbd_tb_pkg;
    import rpbd_pkg::*;

    typedef struct packed {
        t_func       func;
        logic [7:0]  pal_index;
        logic [15:0] pal_color;
        logic [7:0]  a_top_left;
        logic [7:0]  a_top_right;
        logic [7:0]  a_bot_left;
        logic [7:0]  a_bot_right;
        logic [7:0]  b_top_left;
        logic [7:0]  b_top_right;
        logic [7:0]  b_bot_left;
        logic [7:0]  b_bot_right;
    } block_beat_t;

    class pixel_scoreboard;
        logic [15:0] palette [256];
        logic [2:0]  mode_reg;
        logic [7:0]  graph_base;
        logic [7:0]  text_base;
        logic [7:0]  fill_index;
        logic [15:0] pending_pixels [$];
        int unsigned mismatches;

        function new();
            foreach (palette[i]) palette[i] = '0;
            mode_reg   = '0;
            graph_base = '0;
            text_base  = '0;
            fill_index = '0;
            mismatches = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_MODE:       mode_reg   = value[2:0];
                REG_GRAPH_BASE: graph_base = value[7:0];
                REG_TEXT_BASE:  text_base  = value[7:0];
                REG_FILL_INDEX: fill_index = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(t_reg_idx idx);
            case (idx)
                REG_MODE:       return 32'(mode_reg);
                REG_GRAPH_BASE: return 32'(graph_base);
                REG_TEXT_BASE:  return 32'(text_base);
                REG_FILL_INDEX: return 32'(fill_index);
                default:        return '0;
            endcase
        endfunction

        function int unsigned pending();
            return pending_pixels.size();
        endfunction

        // Truncating per-channel mean of the first 1 << shift looked-up colors.
        function logic [15:0] box_average(input logic [7:0] i0, i1, i2, i3,
                                          input int unsigned shift);
            logic [15:0] c [4];
            int unsigned red, green, blue;
            c[0] = palette[i0];
            c[1] = palette[i1];
            c[2] = palette[i2];
            c[3] = palette[i3];
            red   = 0;
            green = 0;
            blue  = 0;
            for (int k = 0; k < (1 << shift); k++) begin
                red   += c[k][15:11];
                green += c[k][10:5];
                blue  += c[k][4:0];
            end
            return {5'(red >> shift), 6'(green >> shift), 5'(blue >> shift)};
        endfunction

        function void note_beat(block_beat_t b);
            logic [7:0]  left, right;
            logic [15:0] px;
            if (b.func == FUNC_PAL_WRITE) begin
                palette[b.pal_index] = b.pal_color;
                return;
            end
            case (mode_reg)
                MODE_SINGLE: px = box_average(8'(b.a_top_left + graph_base),
                                              8'(b.a_top_right + graph_base),
                                              8'(b.a_bot_left + graph_base),
                                              8'(b.a_bot_right + graph_base), 2);
                MODE_DUAL: px = box_average(8'(b.a_top_left + b.b_top_left + graph_base),
                                            8'(b.a_top_right + b.b_top_right + graph_base),
                                            8'(b.a_bot_left + b.b_bot_left + graph_base),
                                            8'(b.a_bot_right + b.b_bot_right + graph_base), 2);
                MODE_INTLV: px = box_average(8'(b.a_top_left + graph_base),
                                             8'(b.a_top_right + graph_base), '0, '0, 1);
                MODE_TEXT: begin
                    // A nonzero high nibble in bottom-row B selects a text color.
                    left = ((b.b_bot_left & TEXT_NIBBLE_MASK) != 0)
                         ? 8'(b.b_bot_left[7:4] + text_base)
                         : 8'(b.a_top_left + graph_base);
                    right = ((b.b_bot_right & TEXT_NIBBLE_MASK) != 0)
                          ? 8'(b.b_bot_right[7:4] + text_base)
                          : 8'(b.a_top_right + graph_base);
                    px = box_average(8'(b.a_top_left + b.b_top_left + graph_base),
                                     8'(b.a_top_right + b.b_top_right + graph_base),
                                     left, right, 2);
                end
                default: px = box_average(fill_index, '0, '0, '0, 0);
            endcase
            pending_pixels.push_back(px);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, want);
        endtask

        task check_pixel(logic [15:0] px);
            logic [15:0] want;
            if (pending_pixels.size() == 0) begin
                report("pixel with none outstanding", 32'(px), '0);
                return;
            end
            want = pending_pixels.pop_front();
            if (px !== want) report("pixel mismatch", 32'(px), 32'(want));
        endtask
    endclass

endpackage

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpbd_pkg::*;
    import rpbd_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS     = 1700;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned LONG_HOLD        = 300;
    localparam logic [2:0]  MODE_LAST_UNUSED = 3'd7;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_func        = 1'b0;
    logic [7:0]  i_pal_index   = '0;
    logic [15:0] i_pal_color   = '0;
    logic [7:0]  i_a_top_left  = '0;
    logic [7:0]  i_a_top_right = '0;
    logic [7:0]  i_a_bot_left  = '0;
    logic [7:0]  i_a_bot_right = '0;
    logic [7:0]  i_b_top_left  = '0;
    logic [7:0]  i_b_top_right = '0;
    logic [7:0]  i_b_bot_left  = '0;
    logic [7:0]  i_b_bot_right = '0;
    logic        i_stall       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;

    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_pixel;
    logic [31:0] prdata;
    logic        pready;

    pixel_scoreboard sb;
    block_beat_t     bus_beat;
    bit              tx_quiet;
    bit              rx_quiet;
    int unsigned     rx_wait;
    int unsigned     hold_left;
    int unsigned     rx_hold_request;
    int unsigned     items_sent;

    rgb565_palette_box_downscale_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_pal_index   (i_pal_index),
        .i_pal_color   (i_pal_color),
        .i_a_top_left  (i_a_top_left),
        .i_a_top_right (i_a_top_right),
        .i_a_bot_left  (i_a_bot_left),
        .i_a_bot_right (i_a_bot_right),
        .i_b_top_left  (i_b_top_left),
        .i_b_top_right (i_b_top_right),
        .i_b_bot_left  (i_b_bot_left),
        .i_b_bot_right (i_b_bot_right),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel       (o_pixel),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign bus_beat = {t_func'(i_func), i_pal_index, i_pal_color,
                       i_a_top_left, i_a_top_right, i_a_bot_left, i_a_bot_right,
                       i_b_top_left, i_b_top_right, i_b_bot_left, i_b_bot_right};

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_beat(bus_beat);
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_pixel(o_pixel);
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 14);
        end
    end

    // Receiver: a long hold-off takes priority over the per-beat wait.
    always @(negedge i_clk) begin
        if (rx_hold_request != 0) begin
            hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_wait != 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_color();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic block_beat_t pixel_beat(input logic [7:0] atl, atr, abl, abr,
                                               input logic [7:0] btl, btr, bbl, bbr);
        block_beat_t b;
        b.func          = FUNC_PIXEL;
        b.pal_index     = 8'($urandom);
        b.pal_color     = 16'($urandom);
        b.a_top_left    = atl;
        b.a_top_right   = atr;
        b.a_bot_left    = abl;
        b.a_bot_right   = abr;
        b.b_top_left    = btl;
        b.b_top_right   = btr;
        b.b_bot_left    = bbl;
        b.b_bot_right   = bbr;
        return b;
    endfunction

    function automatic block_beat_t random_pixel();
        return pixel_beat(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                          rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endfunction

    // Ignored pixel bytes ride along with random content.
    function automatic block_beat_t palette_beat(logic [7:0] idx, logic [15:0] color);
        block_beat_t b;
        b           = random_pixel();
        b.func      = FUNC_PAL_WRITE;
        b.pal_index = idx;
        b.pal_color = color;
        return b;
    endfunction

    // Entered and left just after a falling edge.
    task automatic send_beat(block_beat_t b);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func        <= b.func;
        i_pal_index   <= b.pal_index;
        i_pal_color   <= b.pal_color;
        i_a_top_left  <= b.a_top_left;
        i_a_top_right <= b.a_top_right;
        i_a_bot_left  <= b.a_bot_left;
        i_a_bot_right <= b.a_bot_right;
        i_b_top_left  <= b.b_top_left;
        i_b_top_right <= b.b_top_right;
        i_b_bot_left  <= b.b_bot_left;
        i_b_bot_right <= b.b_bot_right;
        i_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every outstanding pixel, then let the pipe run dry.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_register(t_reg_idx idx, logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, value);
        want = sb.register_value(idx);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) sb.report("register readback", prdata, want);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(logic [2:0] mode, logic [7:0] gbase, tbase, fill);
        settle();
        program_register(REG_MODE, 32'(mode));
        program_register(REG_GRAPH_BASE, 32'(gbase));
        program_register(REG_TEXT_BASE, 32'(tbase));
        program_register(REG_FILL_INDEX, 32'(fill));
    endtask

    initial begin
        int unsigned phase, len, target;
        logic [2:0]  mode;
        block_beat_t b;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Blank mode out of reset reads a cleared palette.
        send_beat(pixel_beat('0, '0, '0, '0, '0, '0, '0, '0));
        send_beat(palette_beat(8'h00, 16'hffff));
        send_beat(palette_beat(8'hff, 16'hf800));
        send_beat(palette_beat(8'h01, 16'h07e0));
        send_beat(palette_beat(8'h02, 16'h001f));
        send_beat(palette_beat(8'h10, 16'h0821));
        send_beat(palette_beat(8'hfe, 16'hffff));

        configure(MODE_BLANK, 8'hff, 8'hff, 8'hff);
        send_beat(random_pixel());
        configure(MODE_LAST_UNUSED, 8'h00, 8'h00, 8'h00);
        send_beat(random_pixel());

        // Graphics base wraps the index at 8 bits.
        configure(MODE_SINGLE, 8'hff, 8'h00, 8'h00);
        send_beat(pixel_beat(8'h01, 8'h02, 8'h03, 8'h11, '0, '0, '0, '0));
        send_beat(pixel_beat(8'hff, 8'hff, 8'hff, 8'hff, '0, '0, '0, '0));
        configure(MODE_DUAL, 8'h01, 8'h00, 8'h00);
        send_beat(pixel_beat(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        send_beat(pixel_beat('0, '0, '0, '0, '0, '0, '0, '0));
        configure(MODE_INTLV, 8'h00, 8'h00, 8'h00);
        send_beat(pixel_beat(8'h00, 8'hff, 8'h01, 8'h02, 8'h10, 8'h20, 8'h30, 8'h40));

        // Text: low nibble only, both text, one side text, all bytes 0xff.
        configure(MODE_TEXT, 8'h00, 8'hf0, 8'h00);
        send_beat(pixel_beat(8'h00, 8'hff, 8'h01, 8'h02, 8'h00, 8'h01, 8'h0f, 8'h00));
        send_beat(pixel_beat(8'h01, 8'h02, 8'h00, 8'h00, 8'hff, 8'h00, 8'hf0, 8'h10));
        send_beat(pixel_beat(8'h10, 8'hfe, 8'h00, 8'h00, 8'h01, 8'h01, 8'h25, 8'h0a));
        send_beat(pixel_beat(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));

        target = items_sent + RANDOM_ITEMS;
        for (int k = 0; k < 256; k++) send_beat(palette_beat(8'(k), rand_color()));

        phase = 0;
        while (items_sent < target) begin
            case ($urandom_range(0, 9))
                0:       mode = MODE_BLANK;
                1:       mode = MODE_LAST_UNUSED - 3'($urandom_range(0, 2));
                default: mode = 3'($urandom_range(MODE_SINGLE, MODE_TEXT));
            endcase
            configure(mode, rand_byte(), rand_byte(), rand_byte());
            tx_quiet = (phase % 4 == 1);
            rx_quiet = tx_quiet;
            // Back-to-back beats against a long receiver hold fill the pipe.
            if (phase % 6 == 2) begin
                tx_quiet = 1'b1;
                rx_hold_request = LONG_HOLD;
            end
            len = $urandom_range(30, 120);
            repeat (len) begin
                if ($urandom_range(0, 4) == 0) begin
                    b = palette_beat(rand_byte(), rand_color());
                end else begin
                    b = random_pixel();
                    if ($urandom_range(0, 1) == 0) b.b_bot_left[7:4] = '0;
                    if ($urandom_range(0, 1) == 0) b.b_bot_right[7:4] = '0;
                end
                send_beat(b);
            end
            phase++;
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS rgb565_palette_box_downscale_core");
        else
            $display("FAIL rgb565_palette_box_downscale_core");
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL rgb565_palette_box_downscale_core");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/rpbd_pkg.sv
design/rgb565_palette_box_downscale_core.sv
tb/rpbd_tb_pkg.sv
tb/tb.sv
